[hdl/vdr_pkg.sv]
// vdr_pkg: shared types, constants and helper functions for the dead-reckoning integrator
// used by vdr_ctrl, vdr_dp and the top level; depends on nothing

package vdr_pkg;

  localparam logic [1:0] MODE_CMD     = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [2:0] REG_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_RC_EN    = 3'd1;
  localparam logic [2:0] REG_RC_RAD   = 3'd2;
  localparam logic [2:0] REG_RC_NEG   = 3'd3;
  localparam logic [2:0] REG_MIN_SPD  = 3'd4;
  localparam logic [2:0] REG_INIT_X   = 3'd5;
  localparam logic [2:0] REG_INIT_Y   = 3'd6;
  localparam logic [2:0] REG_INIT_HDG = 3'd7;

  localparam int CNT_W     = 5;
  localparam int DIV_STEPS = 25;

  typedef struct packed {
    logic             latch;
    logic             decode;
    logic             div_step;
    logic             cor_step;
    logic [CNT_W-1:0] step;
    logic             mul1;
    logic             mul2;
    logic             mul3;
    logic             mul4;
    logic             cor2_init;
    logic             out_load;
  } vdr_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic out_free;
  } vdr_sts_t;

  function automatic logic signed [33:0] atan_of(input logic [CNT_W-1:0] k);
    logic [31:0] a;
    case (k)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return $signed({2'b00, a});
  endfunction

  // round Q2.30 to Q1.14 and clamp to +-1.0
  function automatic logic signed [15:0] q14(input logic signed [33:0] v);
    logic signed [34:0] r;
    r = ($signed({v[33], v}) + 35'sd32768) >>> 16;
    if (r > 35'sd16384) return 16'sd16384;
    else if (r < -35'sd16384) return -16'sd16384;
    else return r[15:0];
  endfunction

endpackage

[hdl/velocity_dead_reckoning_integrator_unit.sv]
// velocity_dead_reckoning_integrator_unit: top level of the planar dead-reckoning integrator
// depends on vdr_pkg, vdr_ctrl and vdr_dp
//
// Usage: items enter on in_* (valid/stall). in_mode selects a velocity command (latches
// vx, vy, wz and clears the time-since-command counter), a tick (integrates dt_us of
// motion) or a restart (loads the initial pose from the config registers). Only a tick
// with nonzero dt_us produces a result on out_*: pose, yaw quaternion z/w in Q1.14,
// held velocities and effective turn rate.
// Config registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high and writes are meant for an idle block.
// Sequence: a command, restart or zero-dt tick passes through accept and decode only. A tick
// goes from accept through decode, the shared divider/cordic step loop, four multiply
// stages, a second cordic pass for the quaternion, then the output register. One item is in
// work at a time; in_stall is high until the current item finishes.
// The output register holds a finished result while out_stall is high; a new item is
// accepted meanwhile and the next result waits for the register to free up.
// Reset (rst_n low, synchronous) restores the config defaults, zeroes pose, velocities
// and counter, and drops out_valid.

module velocity_dead_reckoning_integrator_unit #(
  parameter int CORDIC_STEPS  = 16,
  parameter int POSITION_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic signed [15:0]  in_vx_cmd,
  input  logic signed [15:0]  in_vy_cmd,
  input  logic signed [15:0]  in_wz_cmd,
  input  logic [19:0]         in_dt_us,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  out_x_pos,
  output logic signed [47:0]  out_y_pos,
  output logic [15:0]         out_heading,
  output logic signed [15:0]  out_quat_z,
  output logic signed [15:0]  out_quat_w,
  output logic signed [15:0]  out_vx_out,
  output logic signed [15:0]  out_vy_out,
  output logic signed [20:0]  out_turn_rate_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  vdr_pkg::vdr_cmd_t cmd;
  vdr_pkg::vdr_sts_t sts;

  assign cfg_ready = 1'b1;

  vdr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vdr_dp #(
    .POSITION_BITS(POSITION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_vx_cmd        (in_vx_cmd),
    .in_vy_cmd        (in_vy_cmd),
    .in_wz_cmd        (in_wz_cmd),
    .in_dt_us         (in_dt_us),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x_pos        (out_x_pos),
    .out_y_pos        (out_y_pos),
    .out_heading      (out_heading),
    .out_quat_z       (out_quat_z),
    .out_quat_w       (out_quat_w),
    .out_vx_out       (out_vx_out),
    .out_vy_out       (out_vy_out),
    .out_turn_rate_out(out_turn_rate_out)
  );

endmodule

[hdl/vdr_ctrl.sv]
// vdr_ctrl: sequencer for the dead-reckoning integrator
// depends on vdr_pkg; drives vdr_dp through vdr_cmd_t

module vdr_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  vdr_pkg::vdr_sts_t sts,
  output vdr_pkg::vdr_cmd_t cmd
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DEC   = 10'b0000000010,
    ST_ITER  = 10'b0000000100,
    ST_M1    = 10'b0000001000,
    ST_M2    = 10'b0000010000,
    ST_M3    = 10'b0000100000,
    ST_M4    = 10'b0001000000,
    ST_C2I   = 10'b0010000000,
    ST_ITER2 = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  localparam logic [vdr_pkg::CNT_W-1:0] COR_LAST = vdr_pkg::CNT_W'(CORDIC_STEPS - 1);
  localparam logic [vdr_pkg::CNT_W-1:0] DIV_LAST = vdr_pkg::CNT_W'(vdr_pkg::DIV_STEPS - 1);

  state_t state_r, state_nxt;
  logic [vdr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.decode = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = sts.tick_go ? ST_ITER : ST_IDLE;
      end
      ST_ITER: begin
        // divider and first rotation share the step counter
        cmd.div_step = 1'b1;
        cmd.cor_step = (cnt_r <= COR_LAST);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_M1;
      end
      ST_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        cmd.mul3  = 1'b1;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        cmd.mul4  = 1'b1;
        state_nxt = ST_C2I;
      end
      ST_C2I: begin
        cmd.cor2_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_ITER2;
      end
      ST_ITER2: begin
        cmd.cor_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == COR_LAST) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hdl/vdr_dp.sv]
// vdr_dp: datapath of the dead-reckoning integrator: config registers, pose state,
// divider, cordic, multiplier chain and output register; depends on vdr_pkg

module vdr_dp #(
  parameter int POSITION_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_mode,
  input  logic signed [15:0]  in_vx_cmd,
  input  logic signed [15:0]  in_vy_cmd,
  input  logic signed [15:0]  in_wz_cmd,
  input  logic [19:0]         in_dt_us,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  input  vdr_pkg::vdr_cmd_t   cmd,
  output vdr_pkg::vdr_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  out_x_pos,
  output logic signed [47:0]  out_y_pos,
  output logic [15:0]         out_heading,
  output logic signed [15:0]  out_quat_z,
  output logic signed [15:0]  out_quat_w,
  output logic signed [15:0]  out_vx_out,
  output logic signed [15:0]  out_vy_out,
  output logic signed [20:0]  out_turn_rate_out
);

  localparam int PB = POSITION_BITS;
  localparam logic signed [65:0] PMAX = (66'sd1 <<< (PB - 1)) - 66'sd1;
  localparam logic signed [65:0] PMIN = -PMAX - 66'sd1;
  localparam logic signed [22:0] HEAD_MUL = 23'sd2867081;
  localparam logic signed [33:0] COR_START = 34'sd652032874;
  localparam logic signed [33:0] QUARTER = 34'sh040000000;
  localparam logic signed [33:0] HALF = 34'sh080000000;

  // config
  logic [23:0]        timeout_r;
  logic               rc_en_r, rc_neg_r;
  logic [15:0]        rc_rad_r;
  logic signed [15:0] min_spd_r;
  logic signed [47:0] init_x_r, init_y_r;
  logic [31:0]        init_hdg_r;

  // state
  logic signed [PB-1:0] pos_x_r, pos_y_r;
  logic [31:0]          heading_r;
  logic signed [15:0]   hvx_r, hvy_r, hwz_r;
  logic [23:0]          since_r;

  // latched item
  logic [1:0]         mode_r;
  logic signed [15:0] cvx_r, cvy_r, cwz_r;
  logic [19:0]        dt_r;

  // divider and cordic
  logic [15:0]        rem_r;
  logic [24:0]        quo_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               cneg_r;

  // multiplier chain
  logic signed [20:0] turn_r;
  logic signed [49:0] px1_r, px2_r, py1_r, py2_r;
  logic signed [36:0] rx_r, ry_r;
  logic signed [41:0] hm_r;
  logic signed [63:0] hp_r;
  logic signed [57:0] dx_r, dy_r;

  // decode values
  logic [24:0]        since_sum;
  logic [23:0]        since_tick;
  logic               tmo;
  logic signed [15:0] vx_tick;
  logic [16:0]        avx;
  logic [26:0]        dvd_full;

  always_comb begin
    since_sum  = {1'b0, since_r} + {5'd0, dt_r};
    since_tick = since_sum[24] ? 24'hFFFFFF : since_sum[23:0];
    tmo        = (since_tick > timeout_r);
    vx_tick    = tmo ? 16'sd0 : hvx_r;
    avx        = vx_tick[15] ? (17'd0 - {vx_tick[15], vx_tick}) : {1'b0, vx_tick};
    dvd_full   = avx * 10'd1000;
  end

  assign sts.tick_go = (mode_r == vdr_pkg::MODE_TICK) && (dt_r != 20'd0);

  // divider step
  logic [16:0] dv_t;
  logic [15:0] den;
  logic        dv_ge;
  always_comb begin
    den   = (rc_rad_r < 16'd50) ? 16'd50 : rc_rad_r;
    dv_t  = {rem_r, quo_r[24]};
    dv_ge = (dv_t >= {1'b0, den});
  end

  // cordic fold and step
  logic signed [31:0] cor_ang;
  logic signed [33:0] za, zf;
  logic               zneg;
  logic signed [33:0] xs, ys, at;
  always_comb begin
    cor_ang = cmd.decode ? $signed(heading_r) : ($signed(heading_r) >>> 1);
    za      = {{2{cor_ang[31]}}, cor_ang};
    zneg    = 1'b0;
    zf      = za;
    if (za > QUARTER) begin
      zf   = za - HALF;
      zneg = 1'b1;
    end else if (za < -QUARTER) begin
      zf   = za + HALF;
      zneg = 1'b1;
    end
    xs = cx_r >>> cmd.step;
    ys = cy_r >>> cmd.step;
    at = vdr_pkg::atan_of(cmd.step);
  end

  logic signed [33:0] cos_v, sin_v;
  assign cos_v = cneg_r ? -cx_r : cx_r;
  assign sin_v = cneg_r ? -cy_r : cy_r;

  // reverse-circle term and products
  logic               rev;
  logic signed [20:0] add_v, turn_v;
  logic signed [50:0] dfx, dfy, rxs, rys;
  logic signed [20:0] dts;
  logic signed [64:0] hp_full;
  logic signed [63:0] hsum, hd;
  logic signed [57:0] dxs, dys;
  logic signed [65:0] sx, sy;
  always_comb begin
    rev     = rc_en_r && (hvx_r < min_spd_r);
    add_v   = $signed({1'b0, quo_r[19:0]});
    turn_v  = {{5{hwz_r[15]}}, hwz_r};
    if (rev) turn_v = rc_neg_r ? (turn_v - add_v) : (turn_v + add_v);
    dts     = $signed({1'b0, dt_r});
    dfx     = {px1_r[49], px1_r} - {px2_r[49], px2_r};
    dfy     = {py1_r[49], py1_r} + {py2_r[49], py2_r};
    rxs     = (dfx + 51'sd8192) >>> 14;
    rys     = (dfy + 51'sd8192) >>> 14;
    hp_full = hm_r * HEAD_MUL;
    hsum    = hp_r + 64'sd2097152;
    hd      = hsum >>> 22;
    dxs     = (dx_r + 58'sd32768) >>> 16;
    dys     = (dy_r + 58'sd32768) >>> 16;
    sx      = 66'(pos_x_r) + 66'($signed(dxs[41:0]));
    sy      = 66'(pos_y_r) + 66'($signed(dys[41:0]));
    if (sx > PMAX) sx = PMAX;
    else if (sx < PMIN) sx = PMIN;
    if (sy > PMAX) sy = PMAX;
    else if (sy < PMIN) sy = PMIN;
  end

  // restart load, clamped to the position range
  logic signed [65:0] ix, iy;
  always_comb begin
    ix = 66'(init_x_r);
    iy = 66'(init_y_r);
    if (ix > PMAX) ix = PMAX;
    else if (ix < PMIN) ix = PMIN;
    if (iy > PMAX) iy = PMAX;
    else if (iy < PMIN) iy = PMIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= 24'd300000;
      rc_en_r    <= 1'b0;
      rc_rad_r   <= 16'd400;
      rc_neg_r   <= 1'b0;
      min_spd_r  <= -16'sd20;
      init_x_r   <= '0;
      init_y_r   <= '0;
      init_hdg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vdr_pkg::REG_TIMEOUT:  timeout_r  <= cfg_data[23:0];
        vdr_pkg::REG_RC_EN:    rc_en_r    <= cfg_data[0];
        vdr_pkg::REG_RC_RAD:   rc_rad_r   <= cfg_data[15:0];
        vdr_pkg::REG_RC_NEG:   rc_neg_r   <= cfg_data[0];
        vdr_pkg::REG_MIN_SPD:  min_spd_r  <= cfg_data[15:0];
        vdr_pkg::REG_INIT_X:   init_x_r   <= cfg_data;
        vdr_pkg::REG_INIT_Y:   init_y_r   <= cfg_data;
        vdr_pkg::REG_INIT_HDG: init_hdg_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
      hvx_r     <= '0;
      hvy_r     <= '0;
      hwz_r     <= '0;
      since_r   <= '0;
    end else if (cmd.decode) begin
      case (mode_r)
        vdr_pkg::MODE_CMD: begin
          hvx_r   <= cvx_r;
          hvy_r   <= cvy_r;
          hwz_r   <= cwz_r;
          since_r <= '0;
        end
        vdr_pkg::MODE_RESTART: begin
          pos_x_r   <= ix[PB-1:0];
          pos_y_r   <= iy[PB-1:0];
          heading_r <= init_hdg_r;
          hvx_r     <= '0;
          hvy_r     <= '0;
          hwz_r     <= '0;
          since_r   <= '0;
        end
        vdr_pkg::MODE_TICK: begin
          if (dt_r != 20'd0) begin
            since_r <= since_tick;
            if (tmo) begin
              hvx_r <= '0;
              hvy_r <= '0;
              hwz_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.mul4) begin
      pos_x_r   <= sx[PB-1:0];
      pos_y_r   <= sy[PB-1:0];
      heading_r <= heading_r + hd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      cvx_r  <= in_vx_cmd;
      cvy_r  <= in_vy_cmd;
      cwz_r  <= in_wz_cmd;
      dt_r   <= in_dt_us;
    end
    if (cmd.decode) begin
      rem_r <= '0;
      quo_r <= dvd_full[24:0];
    end else if (cmd.div_step) begin
      rem_r <= dv_ge ? 16'(dv_t - {1'b0, den}) : dv_t[15:0];
      quo_r <= {quo_r[23:0], dv_ge};
    end
    if (cmd.decode || cmd.cor2_init) begin
      cx_r   <= COR_START;
      cy_r   <= '0;
      cz_r   <= zf;
      cneg_r <= zneg;
    end else if (cmd.cor_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.mul1) begin
      turn_r <= turn_v;
      px1_r  <= hvx_r * cos_v;
      px2_r  <= hvy_r * sin_v;
      py1_r  <= hvx_r * sin_v;
      py2_r  <= hvy_r * cos_v;
    end
    if (cmd.mul2) begin
      rx_r <= rxs[36:0];
      ry_r <= rys[36:0];
      hm_r <= turn_r * dts;
    end
    if (cmd.mul3) begin
      dx_r <= rx_r * dts;
      dy_r <= ry_r * dts;
      hp_r <= hp_full[63:0];
    end
  end

  // output register
  logic signed [65:0] ox, oy;
  assign ox = 66'(pos_x_r);
  assign oy = 66'(pos_y_r);
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x_pos         <= ox[47:0];
      out_y_pos         <= oy[47:0];
      out_heading       <= heading_r[31:16];
      out_quat_z        <= vdr_pkg::q14(sin_v);
      out_quat_w        <= vdr_pkg::q14(cos_v);
      out_vx_out        <= hvx_r;
      out_vy_out        <= hvy_r;
      out_turn_rate_out <= turn_r;
    end
  end

endmodule

[hdl/vdr_chk.sv]
// vdr_chk: port-level checks for the dead-reckoning integrator
// bound to velocity_dead_reckoning_integrator_unit; depends on nothing else

module vdr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_quat_w
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // the block is busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken without decode");

  // no result appears the cycle after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // half-angle cosine is never negative
  a_quat_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_quat_w[15])
    else $error("quat_w negative");

endmodule

bind velocity_dead_reckoning_integrator_unit vdr_chk u_chk (.*);

[tb/vdr_pose_checker.sv]
// vdr_pose_checker: watches the item, result and register channels of the dead-reckoning
// integrator, predicts each pose result and compares it field by field; uses vdr_pkg
`timescale 1ns / 100ps

module vdr_pose_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [15:0] in_vx_cmd,
  input  logic signed [15:0] in_vy_cmd,
  input  logic signed [15:0] in_wz_cmd,
  input  logic [19:0]        in_dt_us,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [47:0] out_x_pos,
  input  logic signed [47:0] out_y_pos,
  input  logic [15:0]        out_heading,
  input  logic signed [15:0] out_quat_z,
  input  logic signed [15:0] out_quat_w,
  input  logic signed [15:0] out_vx_out,
  input  logic signed [15:0] out_vy_out,
  input  logic signed [20:0] out_turn_rate_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic [15:0]        hdg;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [20:0] turn;
  } pose_t;

  localparam longint POS_MAX = 64'sh00007FFFFFFFFFFF;
  localparam longint POS_MIN = -POS_MAX - 1;

  pose_t pose_q[$];

  // register copies
  logic [23:0]        timeout_us;
  logic               rc_en;
  logic [15:0]        rc_radius;
  logic               rc_neg;
  logic signed [15:0] rc_min_speed;
  logic signed [47:0] init_x;
  logic signed [47:0] init_y;
  logic [31:0]        init_hdg;

  // pose state
  longint      x_nm, y_nm;
  logic [31:0] hdg_acc;
  longint      vx_hold, vy_hold, wz_hold;
  logic [23:0] since_cmd;

  function automatic longint round_shift(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v);
    longint r;
    r = round_shift(v, 16);
    if (r > 16384) r = 16384;
    else if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic longint clamp_add(input longint a, input longint d);
    longint t;
    t = a + d;
    return (t > POS_MAX) ? POS_MAX : ((t < POS_MIN) ? POS_MIN : t);
  endfunction

  // rotation-mode cordic on a signed 32-bit binary angle, outputs Q2.30
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint atan_lut[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    longint x, y, z, nx, a;
    bit flip;
    x = 652032874;
    y = 0;
    z = ang;
    flip = 0;
    // fold into the right half plane
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      a = (i < 24) ? atan_lut[i] : 0;
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= a;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += a;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  task automatic integrate_tick(input logic [19:0] dt);
    logic [24:0] sum;
    longint turn, add, rad, c, s, r, d, hs;
    pose_t p;
    sum = since_cmd + dt;
    since_cmd = (sum > 25'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
    if (since_cmd > timeout_us) begin
      vx_hold = 0;
      vy_hold = 0;
      wz_hold = 0;
    end
    turn = wz_hold;
    // constant curvature while reversing
    if (rc_en && vx_hold < longint'(rc_min_speed)) begin
      rad = (rc_radius < 50) ? 50 : rc_radius;
      add = (1000 * (vx_hold < 0 ? -vx_hold : vx_hold)) / rad;
      turn += rc_neg ? -add : add;
    end
    hs = longint'($signed(hdg_acc));
    sin_cos(hs, c, s);
    r = round_shift(vx_hold * c - vy_hold * s, 14);
    d = round_shift(r * longint'(dt), 16);
    x_nm = clamp_add(x_nm, d);
    r = round_shift(vx_hold * s + vy_hold * c, 14);
    d = round_shift(r * longint'(dt), 16);
    y_nm = clamp_add(y_nm, d);
    d = round_shift(turn * longint'(dt) * 2867081, 22);
    hdg_acc = hdg_acc + d[31:0];
    hs = longint'($signed(hdg_acc));
    sin_cos(hs >>> 1, c, s);
    p.x = x_nm[47:0];
    p.y = y_nm[47:0];
    p.hdg = hdg_acc[31:16];
    p.qz = to_q14(s);
    p.qw = to_q14(c);
    p.vx = vx_hold[15:0];
    p.vy = vy_hold[15:0];
    p.turn = turn[20:0];
    pose_q.push_back(p);
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      timeout_us = 24'd300000;
      rc_en = 1'b0;
      rc_radius = 16'd400;
      rc_neg = 1'b0;
      rc_min_speed = -16'sd20;
      init_x = '0;
      init_y = '0;
      init_hdg = '0;
      x_nm = 0;
      y_nm = 0;
      hdg_acc = '0;
      vx_hold = 0;
      vy_hold = 0;
      wz_hold = 0;
      since_cmd = '0;
      pose_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $display("%0t: result transfer with no pose expected, actual x %0d",
                   $time, out_x_pos);
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          check_field("x_pos", e.x, out_x_pos);
          check_field("y_pos", e.y, out_y_pos);
          check_field("heading", e.hdg, out_heading);
          check_field("quat_z", e.qz, out_quat_z);
          check_field("quat_w", e.qw, out_quat_w);
          check_field("vx_out", e.vx, out_vx_out);
          check_field("vy_out", e.vy, out_vy_out);
          check_field("turn_rate_out", e.turn, out_turn_rate_out);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vdr_pkg::REG_TIMEOUT:  timeout_us = cfg_data[23:0];
          vdr_pkg::REG_RC_EN:    rc_en = cfg_data[0];
          vdr_pkg::REG_RC_RAD:   rc_radius = cfg_data[15:0];
          vdr_pkg::REG_RC_NEG:   rc_neg = cfg_data[0];
          vdr_pkg::REG_MIN_SPD:  rc_min_speed = cfg_data[15:0];
          vdr_pkg::REG_INIT_X:   init_x = cfg_data;
          vdr_pkg::REG_INIT_Y:   init_y = cfg_data;
          vdr_pkg::REG_INIT_HDG: init_hdg = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_mode)
          vdr_pkg::MODE_CMD: begin
            vx_hold = in_vx_cmd;
            vy_hold = in_vy_cmd;
            wz_hold = in_wz_cmd;
            since_cmd = '0;
          end
          vdr_pkg::MODE_RESTART: begin
            x_nm = init_x;
            y_nm = init_y;
            hdg_acc = init_hdg;
            vx_hold = 0;
            vy_hold = 0;
            wz_hold = 0;
            since_cmd = '0;
          end
          vdr_pkg::MODE_TICK: if (in_dt_us != 0) integrate_tick(in_dt_us);
          default: ;
        endcase
      end
    end
    pending = pose_q.size();
  end

endmodule

[tb/velocity_dead_reckoning_integrator_unit_tb.sv]
// velocity_dead_reckoning_integrator_unit_tb: drives commands, ticks, restarts and register
// writes into the integrator; depends on vdr_pkg, the block and vdr_pose_checker
`timescale 1ns / 100ps

module velocity_dead_reckoning_integrator_unit_tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [47:0] X_MAX = 48'h7FFFFFFFFFFF;
  localparam logic [47:0] X_MIN = 48'h800000000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_mode;
  logic signed [15:0] in_vx_cmd, in_vy_cmd, in_wz_cmd;
  logic [19:0]        in_dt_us;
  logic               out_valid;
  logic               out_stall;
  logic signed [47:0] out_x_pos, out_y_pos;
  logic [15:0]        out_heading;
  logic signed [15:0] out_quat_z, out_quat_w, out_vx_out, out_vy_out;
  logic signed [20:0] out_turn_rate_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [47:0]        cfg_data;
  int                 fail_count;
  int                 pending;
  bit                 hold_off_req;
  int                 idle_cycles;

  velocity_dead_reckoning_integrator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_vx_cmd(in_vx_cmd), .in_vy_cmd(in_vy_cmd), .in_wz_cmd(in_wz_cmd),
    .in_dt_us(in_dt_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_pos(out_x_pos), .out_y_pos(out_y_pos), .out_heading(out_heading),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_vx_out(out_vx_out), .out_vy_out(out_vy_out),
    .out_turn_rate_out(out_turn_rate_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  vdr_pose_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_vx_cmd(in_vx_cmd), .in_vy_cmd(in_vy_cmd), .in_wz_cmd(in_wz_cmd),
    .in_dt_us(in_dt_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x_pos(out_x_pos), .out_y_pos(out_y_pos), .out_heading(out_heading),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_vx_out(out_vx_out), .out_vy_out(out_vy_out),
    .out_turn_rate_out(out_turn_rate_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(10, 50);
  endfunction

  // one item transfer; called and returns right after a rising edge
  task automatic send_item(input logic [1:0] mode, input logic [15:0] vx,
                           input logic [15:0] vy, input logic [15:0] wz,
                           input logic [19:0] dt);
    int gap;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_vx_cmd <= vx;
    in_vy_cmd <= vy;
    in_wz_cmd <= wz;
    in_dt_us <= dt;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick(input logic [19:0] dt);
    send_item(vdr_pkg::MODE_TICK, '0, '0, '0, dt);
  endtask

  task automatic send_cmd(input logic [15:0] vx, input logic [15:0] vy,
                          input logic [15:0] wz);
    send_item(vdr_pkg::MODE_CMD, vx, vy, wz, '0);
  endtask

  // let every pose drain, then allow for a zero-result item still in work
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [23:0] tmo, input logic en, input logic [15:0] rad,
                           input logic neg, input logic [15:0] spd, input logic [47:0] ix,
                           input logic [47:0] iy, input logic [31:0] ih);
    write_reg(vdr_pkg::REG_TIMEOUT, 48'(tmo));
    write_reg(vdr_pkg::REG_RC_EN, 48'(en));
    write_reg(vdr_pkg::REG_RC_RAD, 48'(rad));
    write_reg(vdr_pkg::REG_RC_NEG, 48'(neg));
    write_reg(vdr_pkg::REG_MIN_SPD, 48'(spd));
    write_reg(vdr_pkg::REG_INIT_X, ix);
    write_reg(vdr_pkg::REG_INIT_Y, iy);
    write_reg(vdr_pkg::REG_INIT_HDG, 48'(ih));
  endtask

  function automatic logic [19:0] random_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    else if (r < 12) return 20'($urandom);
    else if (r < 20) return 20'($urandom_range(1, 50));
    else return 20'($urandom_range(1000, 40000));
  endfunction

  function automatic logic [15:0] random_vel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($signed($urandom_range(0, 4000)) - 2000);
    else return 16'($urandom);
  endfunction

  // receiver: random stalls, calm stretches, and one long hold-off on request
  initial begin
    int phase_cycles;
    bit calm;
    out_stall = 1'b0;
    calm = 1'b0;
    phase_cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (700) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (++phase_cycles >= 300) begin
          phase_cycles = 0;
          calm = ($urandom_range(0, 3) == 0);
        end
        if (calm) out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 5) out_stall <= 1'b1;
        else if (out_stall && $urandom_range(0, 99) < 8) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int counted;
    int r;
    logic [1:0] mode;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = vdr_pkg::MODE_CMD;
    in_vx_cmd = '0;
    in_vy_cmd = '0;
    in_wz_cmd = '0;
    in_dt_us = '0;
    cfg_valid = 1'b0;
    cfg_index = vdr_pkg::REG_TIMEOUT;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, field extremes, zero dt, unused mode, timeout expiry
    send_tick(20'd1);
    send_cmd(16'h7FFF, 16'h8000, 16'h7FFF);
    send_tick(20'd1);
    send_tick(20'd0);
    send_item(vdr_pkg::MODE_NONE, 16'h1234, 16'h5678, 16'h9ABC, 20'hFFFFF);
    send_tick(20'hFFFFF);
    send_cmd(16'h8000, 16'h7FFF, 16'h8000);
    send_tick(20'd20000);
    send_item(vdr_pkg::MODE_RESTART, '0, '0, '0, '0);
    send_cmd(16'hFFEB, 16'd0, 16'd0);
    send_tick(20'd5000);
    wait_idle();

    // saturating position, reverse circle at smallest radius, counter never expires
    write_all(24'hFFFFFF, 1'b1, 16'd7, 1'b0, 16'h7FFF, X_MAX, X_MIN, 32'hFFFFFFFF);
    send_item(vdr_pkg::MODE_RESTART, '0, '0, '0, '0);
    send_cmd(16'h7FFF, 16'h8000, 16'h7FFF);
    repeat (18) send_tick(20'hFFFFF);
    send_cmd(16'h8000, 16'h7FFF, 16'h8000);
    send_tick(20'hFFFFF);
    wait_idle();

    write_all(24'd0, 1'b1, 16'hFFFF, 1'b1, 16'h8000, X_MIN, X_MAX, 32'h80000000);
    send_item(vdr_pkg::MODE_RESTART, '0, '0, '0, '0);
    send_cmd(16'h8000, 16'd100, 16'd0);
    send_tick(20'd1);
    wait_idle();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_all(24'd300000, 1'b0, 16'd400, 1'b0, 16'hFFEC, '0, '0, '0);
        1: write_all(24'd50000, 1'b1, 16'd50, 1'b0, 16'hFFEC, 48'd1000000, 48'hFFFFFFF00000,
                     32'h40000000);
        2: write_all(24'($urandom), 1'b1, 16'($urandom), 1'b1, 16'($urandom),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom);
        default: write_all(24'($urandom_range(0, 400000)), 1'($urandom_range(0, 1)),
                           16'($urandom_range(0, 2000)), 1'($urandom_range(0, 1)),
                           16'($urandom_range(0, 100)), 48'($signed($urandom)),
                           48'($signed($urandom)), $urandom);
      endcase
      if (ph == 1) hold_off_req = 1'b1;
      send_item(vdr_pkg::MODE_RESTART, '0, '0, '0, '0);
      counted = 0;
      while (counted < 100) begin
        r = $urandom_range(0, 99);
        if (r < 25) mode = vdr_pkg::MODE_CMD;
        else if (r < 90) mode = vdr_pkg::MODE_TICK;
        else if (r < 95) mode = vdr_pkg::MODE_RESTART;
        else mode = vdr_pkg::MODE_NONE;
        if (mode != vdr_pkg::MODE_NONE) counted++;
        send_item(mode, random_vel(), random_vel(), random_vel(), random_dt());
      end
      wait_idle();
    end

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
